### rtl/i2cm_seq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Operation codes, item types and schedule constants.
// ----------------------------------------------------------------------------
package i2cm_seq_pkg;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam int unsigned BitsPerByte = 8;
  localparam logic [4:0] BytePhases = 5'(2 * BitsPerByte);
  localparam logic [4:0] AckHigh    = 5'(2 * BitsPerByte + 1);
  localparam logic [4:0] LastLong   = 5'(2 * BitsPerByte + 2);

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_data;
  } res_t;

endpackage
`default_nettype wire

### rtl/i2cm_seq_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface i2cm_seq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_byte;
  logic       ack_level;
  logic       sda_in;

  modport source (output valid, output operation, output data_byte,
                  output ack_level, output sda_in, input ready);
  modport sink (input valid, input operation, input data_byte,
                input ack_level, input sda_in, output ready);
endinterface

interface i2cm_seq_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       done_res;
  logic       ack_received;
  logic [7:0] read_data;

  modport source (output valid, output scl_level, output sda_level,
                  output done_res, output ack_received, output read_data,
                  input ready);
  modport sink (input valid, input scl_level, input sda_level,
                input done_res, input ack_received, input read_data,
                output ready);
endinterface
`default_nettype wire

### rtl/i2cm_seq_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer engine
// Command state, interval counter and shift register; one step per item.
// ----------------------------------------------------------------------------
module i2cm_seq_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire i2cm_seq_pkg::item_t item_i,
  output      i2cm_seq_pkg::res_t  res_o
);
  import i2cm_seq_pkg::*;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_IDLE  = 3'd7
  } cmd_e;

  cmd_e       cmd_q, cmd_d;
  logic [4:0] cnt_q, cnt_d;
  logic [7:0] shift_q, shift_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       ack_q, ack_d;
  logic       ack_send_q, ack_send_d;

  logic       scl, sda, last, ack_out;
  logic [7:0] data_out;
  logic       is_tick;

  assign is_tick = (item_i.operation == OP_TICK);

  always_comb begin
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    ack_d      = ack_q;
    ack_send_d = ack_send_q;
    scl        = 1'b1;
    sda        = 1'b1;
    last       = 1'b0;
    ack_out    = 1'b0;
    data_out   = 8'd0;

    if (!is_tick) begin
      if (item_i.operation <= OP_READ && cmd_q == CMD_IDLE) begin
        cmd_d = cmd_e'(item_i.operation);
        cnt_d = 5'd0;
        if (item_i.operation == OP_WRITE) begin
          shift_d = item_i.data_byte;
        end else if (item_i.operation == OP_READ) begin
          shift_d    = 8'd0;
          ack_send_d = item_i.ack_level;
        end
      end
    end else begin
      case (cmd_q)
        CMD_START: begin
          sda  = (cnt_q == 5'd0);
          last = (cnt_q != 5'd0);
        end
        CMD_STOP: begin
          sda  = (cnt_q != 5'd0);
          last = (cnt_q != 5'd0);
        end
        CMD_WRITE: begin
          if (cnt_q < BytePhases) begin
            scl = cnt_q[0];
            sda = shift_q[7];
            if (scl) shift_d = {shift_q[6:0], 1'b0};
          end else begin
            scl  = (cnt_q == AckHigh);
            if (scl) ack_d = item_i.sda_in;
            last = (cnt_q >= LastLong);
            if (last) ack_out = ack_q;
          end
        end
        CMD_READ: begin
          if (cnt_q < BytePhases) begin
            scl = cnt_q[0];
            if (scl) shift_d = {shift_q[6:0], item_i.sda_in};
          end else begin
            sda  = ack_send_q;
            scl  = (cnt_q == AckHigh);
            last = (cnt_q >= LastLong);
            if (last) data_out = shift_q;
          end
        end
        default: begin
          scl = scl_q;
          sda = sda_q;
        end
      endcase

      if (cmd_q != CMD_IDLE) begin
        scl_d = scl;
        sda_d = sda;
        if (last) begin
          if (cmd_q == CMD_START) begin
            scl_d = 1'b0;
            sda_d = 1'b0;
          end
          cmd_d = CMD_IDLE;
          cnt_d = 5'd0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
    end
  end

  assign res_o.scl_level    = scl;
  assign res_o.sda_level    = sda;
  assign res_o.done_res     = last;
  assign res_o.ack_received = ack_out;
  assign res_o.read_data    = data_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= CMD_IDLE;
      cnt_q      <= 5'd0;
      shift_q    <= 8'd0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      ack_q      <= 1'b0;
      ack_send_q <= 1'b0;
    end else if (step_i) begin
      cmd_q      <= cmd_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      ack_q      <= ack_d;
      ack_send_q <= ack_send_d;
    end
  end

endmodule
`default_nettype wire

### rtl/i2c_master_bit_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// A tick item's result goes through the input register, then the result register.
// Throughput: one item per clock while the result register is free; set by
// the engine step between the input register and the result register.
// Commands give no result and pass without waiting on the result register.
// Reset: asynchronous, active low; idle, SCL and SDA released, both
// registers empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  i2cm_seq_in_if.sink    in_i,
  i2cm_seq_out_if.source out_o
);
  import i2cm_seq_pkg::*;

  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  res_t  out_res_q;

  res_t  res;
  logic  out_free;
  logic  advance;
  logic  in_ready;
  logic  is_tick;

  assign is_tick  = (in_item_q.operation == OP_TICK);
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && (!is_tick || out_free);
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready = in_ready;

  i2cm_seq_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_item_q.operation <= in_i.operation;
      in_item_q.data_byte <= in_i.data_byte;
      in_item_q.ack_level <= in_i.ack_level;
      in_item_q.sda_in    <= in_i.sda_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_tick) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.scl_level    = out_res_q.scl_level;
  assign out_o.sda_level    = out_res_q.sda_level;
  assign out_o.done_res     = out_res_q.done_res;
  assign out_o.ack_received = out_res_q.ack_received;
  assign out_o.read_data    = out_res_q.read_data;

endmodule
`default_nettype wire
